### design/mpa_sync_pkg.sv
// ----------------------------------------------------------------------------
// mpa_sync_pkg
// shared constants, header tables and controller/datapath signal groups
// ----------------------------------------------------------------------------
package mpa_sync_pkg;

    // buffer limit and derived widths
    localparam int MAX_BUFFER_BYTES = 65536;
    localparam int CNT_W            = $clog2(MAX_BUFFER_BYTES + 1);
    localparam int OFF_W            = 17;
    localparam int LEN_W            = 12;

    // divider widths: quotient stays below 2^QUO_W for every legal header
    localparam int QUO_W   = 12;
    localparam int HZ_W    = 16;
    localparam int REM_W   = HZ_W + QUO_W - 1;
    localparam int STEP_W  = $clog2(QUO_W);
    localparam int KBPS_W  = 9;
    localparam int SPF8_W  = 8;
    localparam int PROD_W  = KBPS_W + SPF8_W;
    localparam int KILO    = 1000;

    // header field codes
    localparam logic [10:0] SYNC_PATTERN = 11'h7FF;
    localparam logic [1:0]  VER_MPEG1    = 2'b11;
    localparam logic [1:0]  VER_MPEG2    = 2'b10;
    localparam logic [1:0]  VER_RESERVED = 2'b01;
    localparam logic [1:0]  LAY_RESERVED = 2'b00;
    localparam logic [1:0]  LAY_ONE      = 2'b11;
    localparam logic [3:0]  BRI_FREE     = 4'h0;
    localparam logic [3:0]  BRI_BAD      = 4'hF;
    localparam logic [1:0]  SRI_RESERVED = 2'b11;

    // kbps by [mpeg1, mpeg2/2.5][layer I, II, III][index]
    localparam logic [KBPS_W-1:0] KBPS_TAB [0:1][0:2][0:15] = '{
        '{ '{0,32,64,96,128,160,192,224,256,288,320,352,384,416,448,0},
           '{0,32,48,56,64,80,96,112,128,160,192,224,256,320,384,0},
           '{0,32,40,48,56,64,80,96,112,128,160,192,224,256,320,0} },
        '{ '{0,32,48,56,64,80,96,112,128,144,160,176,192,224,256,0},
           '{0,8,16,24,32,40,48,56,64,80,96,112,128,144,160,0},
           '{0,8,16,24,32,40,48,56,64,80,96,112,128,144,160,0} }
    };

    // sample rate in hz by [rate code][mpeg1, mpeg2, mpeg2.5]
    localparam logic [HZ_W-1:0] RATE_TAB [0:2][0:2] = '{
        '{44100, 22050, 11025},
        '{48000, 24000, 12000},
        '{32000, 16000, 8000}
    };

    // samples per frame divided by 8, by [layer I, II, III][mpeg1, mpeg2, mpeg2.5]
    localparam logic [SPF8_W-1:0] SPF8_TAB [0:2][0:2] = '{
        '{48, 48, 48},
        '{144, 144, 144},
        '{144, 72, 72}
    };

    // controller to datapath
    typedef struct packed {
        logic take;       // input transaction this cycle
        logic load_miss;  // buffer ended with no header
        logic start_div;  // load dividend and divisor
        logic div_step;   // one quotient bit
        logic load_len;   // quotient plus padding to output
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic hit;        // current byte completes a valid header
        logic miss_end;   // current byte ends the buffer with no header
        logic div_last;   // last quotient bit in progress
    } t_sts;

endpackage

### design/mpa_sync_dp.sv
// ----------------------------------------------------------------------------
// mpa_sync_dp
// header window, byte counter, frame length divider and result registers
// ----------------------------------------------------------------------------
module mpa_sync_dp
    import mpa_sync_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [7:0]        i_data_byte,
    input  logic              i_last_byte,
    input  t_cmd              i_cmd,
    output t_sts              o_sts,
    output logic              o_found,
    output logic [OFF_W-1:0]  o_header_offset,
    output logic [LEN_W-1:0]  o_frame_length
);

    // scan state
    logic [31:0]       r_window;
    logic [CNT_W-1:0]  r_count;
    logic              r_already;

    // divider
    logic [PROD_W-1:0] r_prod;
    logic [HZ_W-1:0]   r_hz;
    logic [2:0]        r_pad_add;
    logic [REM_W-1:0]  r_rem;
    logic [REM_W-1:0]  r_dsr;
    logic [QUO_W-1:0]  r_quo;
    logic [STEP_W-1:0] r_step;

    // result
    logic              r_out_found;
    logic [OFF_W-1:0]  r_out_offset;
    logic [LEN_W-1:0]  r_out_len;

    logic [31:0]       win_next;
    logic              scan_en;
    logic [CNT_W-1:0]  count_next;
    logic [CNT_W-1:0]  count_eff;
    logic [1:0]        ver;
    logic [1:0]        lay;
    logic [3:0]        bri;
    logic [1:0]        sri;
    logic              pad;
    logic              hdr_ok;
    logic [1:0]        lsel;
    logic [1:0]        vsel;
    logic [1:0]        sri_c;
    logic              row2;
    logic [KBPS_W-1:0] kbps;
    logic [SPF8_W-1:0] spf8;
    logic              hit;
    logic              ge;

    assign win_next   = {r_window[23:0], i_data_byte};
    assign scan_en    = !r_already && (r_count < CNT_W'(MAX_BUFFER_BYTES));
    assign count_next = r_count + CNT_W'(1);
    assign count_eff  = scan_en ? count_next : r_count;

    assign ver = win_next[20:19];
    assign lay = win_next[18:17];
    assign bri = win_next[15:12];
    assign sri = win_next[11:10];
    assign pad = win_next[9];

    assign hdr_ok = (win_next[31:21] == SYNC_PATTERN) && (ver != VER_RESERVED)
                 && (lay != LAY_RESERVED) && (bri != BRI_FREE) && (bri != BRI_BAD)
                 && (sri != SRI_RESERVED);

    // table indexes, clamped so reserved codes stay in range
    always_comb begin
        lsel = (lay == LAY_RESERVED) ? 2'd0 : 2'd3 - lay;
        case (ver)
            VER_MPEG1: vsel = 2'd0;
            VER_MPEG2: vsel = 2'd1;
            default:   vsel = 2'd2;
        endcase
        sri_c = (sri == SRI_RESERVED) ? 2'd0 : sri;
        row2  = (vsel != 2'd0);
    end

    assign kbps = KBPS_TAB[row2][lsel][bri];
    assign spf8 = SPF8_TAB[lsel][vsel];
    assign hit  = scan_en && hdr_ok;

    assign ge = (r_rem >= r_dsr);

    assign o_sts.hit      = hit;
    assign o_sts.miss_end = i_last_byte && !r_already && !hit;
    assign o_sts.div_last = (r_step == '0);

    // scan state, cleared at buffer end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window  <= '0;
            r_count   <= '0;
            r_already <= 1'b0;
        end else if (i_cmd.take) begin
            if (i_last_byte) begin
                r_window  <= '0;
                r_count   <= '0;
                r_already <= 1'b0;
            end else begin
                if (scan_en) begin
                    r_window <= win_next;
                    r_count  <= count_next;
                end
                if (hit) begin
                    r_already <= 1'b1;
                end
            end
        end
    end

    // header capture, divider and result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.take && hit) begin
            r_prod       <= PROD_W'(spf8 * kbps);
            r_hz         <= RATE_TAB[sri_c][vsel];
            r_pad_add    <= (lay == LAY_ONE) ? {pad, 2'b00} : {2'b00, pad};
            r_out_found  <= 1'b1;
            r_out_offset <= OFF_W'(count_next - CNT_W'(4));
        end
        if (i_cmd.load_miss) begin
            r_out_found  <= 1'b0;
            r_out_offset <= OFF_W'(count_eff);
            r_out_len    <= '0;
        end
        if (i_cmd.start_div) begin
            r_rem  <= REM_W'(r_prod * 10'(KILO));
            r_dsr  <= {r_hz, (QUO_W - 1)'(0)};
            r_quo  <= '0;
            r_step <= STEP_W'(QUO_W - 1);
        end
        if (i_cmd.div_step) begin
            if (ge) begin
                r_rem <= r_rem - r_dsr;
            end
            r_dsr  <= r_dsr >> 1;
            r_quo  <= {r_quo[QUO_W-2:0], ge};
            r_step <= r_step - STEP_W'(1);
        end
        if (i_cmd.load_len) begin
            r_out_len <= LEN_W'(r_quo + QUO_W'(r_pad_add));
        end
    end

    assign o_found         = r_out_found;
    assign o_header_offset = r_out_offset;
    assign o_frame_length  = r_out_len;

endmodule

### design/mpa_sync_ctrl.sv
// ----------------------------------------------------------------------------
// mpa_sync_ctrl
// sequencer for scanning, frame length division and result handoff
// ----------------------------------------------------------------------------
module mpa_sync_ctrl
    import mpa_sync_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_SCAN,
        S_MUL,
        S_DIV,
        S_FIN,
        S_OUT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_in_ready;
    logic   n_in_ready;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   take;
    logic   pop;

    assign take = i_in_valid && r_in_ready;
    assign pop  = r_out_valid && i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_in_ready  = r_in_ready;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        o_cmd.take  = take;
        case (r_state)
            S_SCAN: begin
                if (take && i_sts.hit) begin
                    n_state    = S_MUL;
                    n_in_ready = 1'b0;
                end else if (take && i_sts.miss_end) begin
                    o_cmd.load_miss = 1'b1;
                    n_state         = S_OUT;
                    n_in_ready      = 1'b0;
                    n_out_valid     = 1'b1;
                end
            end
            S_MUL: begin
                o_cmd.start_div = 1'b1;
                n_state         = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.load_len = 1'b1;
                n_state        = S_OUT;
                n_out_valid    = 1'b1;
            end
            S_OUT: begin
                if (pop) begin
                    n_state     = S_SCAN;
                    n_out_valid = 1'b0;
                    n_in_ready  = 1'b1;
                end
            end
            default: begin
                n_state     = S_SCAN;
                n_out_valid = 1'b0;
                n_in_ready  = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_SCAN;
            r_in_ready  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_in_ready  <= n_in_ready;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = r_in_ready;
    assign o_out_valid = r_out_valid;

    // a pending result blocks the input side
    a_out_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !r_in_ready)
        else $error("input ready while result pending");

    // a header match starts the length computation
    a_hit_starts_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && take && i_sts.hit) |=> (r_state == S_MUL))
        else $error("header match did not start length computation");

    // divider runs until its last step
    a_div_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && !i_sts.div_last) |=> (r_state == S_DIV))
        else $error("divider left early");

    // a result shows only after the length is loaded or a miss is reported
    a_valid_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(o_cmd.load_len) || $past(o_cmd.load_miss)))
        else $error("result valid without a load");

endmodule

### design/mpeg_audio_frame_sync_finder_top.sv
// ----------------------------------------------------------------------------
// mpeg_audio_frame_sync_finder_top
// finds the first valid mpeg audio frame header in a byte buffer
// ----------------------------------------------------------------------------
// input channel: one buffer byte per transaction, i_last_byte marks the end
// of the buffer. output channel: one result per buffer, either the first
// valid header (offset of its first byte and frame length in bytes) or,
// on the last byte, found = 0 with the buffer length and frame length 0.
// throughput: one byte per cycle while scanning. a header match holds the
// input while the dividend is formed, the bit-serial divider runs (one
// quotient bit per cycle) and the padding is added; then the result is
// shown. a miss result shows the cycle after the last byte. bytes after
// a match are taken one per cycle and ignored.
// while a result is pending the input is held off; a stalled receiver
// therefore stalls the byte stream, and the result holds until taken.
// reset clears the window, byte count, header-seen flag and any pending result;
// the block is ready for bytes right after reset.
// bytes beyond MAX_BUFFER_BYTES are not scanned and the count saturates.
// ----------------------------------------------------------------------------
module mpeg_audio_frame_sync_finder_top
    import mpa_sync_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // byte stream
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [7:0]        i_data_byte,
    input  logic              i_last_byte,
    // result
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_found,
    output logic [OFF_W-1:0]  o_header_offset,
    output logic [LEN_W-1:0]  o_frame_length
);

    t_cmd cmd;
    t_sts sts;

    // sequencer: scan, divide, hand off
    mpa_sync_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // window, counter, tables, divider and result registers
    mpa_sync_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_data_byte     (i_data_byte),
        .i_last_byte     (i_last_byte),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .o_found         (o_found),
        .o_header_offset (o_header_offset),
        .o_frame_length  (o_frame_length)
    );

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the mpeg audio frame sync finder
// ----------------------------------------------------------------------------
// streams byte buffers into the finder, mirrors its header scan in a local
// model and checks every result transaction against the oldest predicted
// result. a short table of hand-made buffers comes first, then random
// buffers that mostly carry a legal header in noise. both channels idle at
// random.
// ----------------------------------------------------------------------------
module tb_top;
    import mpa_sync_pkg::MAX_BUFFER_BYTES;
    import mpa_sync_pkg::OFF_W;
    import mpa_sync_pkg::LEN_W;

    // header field codes as the bench sees them
    localparam logic [10:0] HDR_SYNC   = 11'h7FF;
    localparam logic [1:0]  VER_ONE    = 2'b11;
    localparam logic [1:0]  VER_TWO    = 2'b10;
    localparam logic [1:0]  VER_TWO_5  = 2'b00;
    localparam logic [1:0]  VER_RSVD   = 2'b01;
    localparam logic [1:0]  LAYER_RSVD = 2'b00;
    localparam logic [3:0]  BR_FREE    = 4'h0;
    localparam logic [3:0]  BR_BAD     = 4'hF;
    localparam logic [1:0]  SR_RSVD    = 2'b11;

    // kbps for mpeg1, by [layer I, II, III][index]
    localparam int unsigned KBPS_V1 [3][16] = '{
        '{0,32,64,96,128,160,192,224,256,288,320,352,384,416,448,0},
        '{0,32,48,56,64,80,96,112,128,160,192,224,256,320,384,0},
        '{0,32,40,48,56,64,80,96,112,128,160,192,224,256,320,0}
    };
    // kbps for mpeg2 and mpeg2.5, by [layer I, II, III][index]
    localparam int unsigned KBPS_LSF [3][16] = '{
        '{0,32,48,56,64,80,96,112,128,144,160,176,192,224,256,0},
        '{0,8,16,24,32,40,48,56,64,80,96,112,128,144,160,0},
        '{0,8,16,24,32,40,48,56,64,80,96,112,128,144,160,0}
    };
    // sample rate by [rate code][mpeg1, mpeg2, mpeg2.5]
    localparam int unsigned RATE_HZ [3][3] = '{
        '{44100, 22050, 11025},
        '{48000, 24000, 12000},
        '{32000, 16000, 8000}
    };
    // samples per frame over 8, by [layer I, II, III][mpeg1, mpeg2, mpeg2.5]
    localparam int unsigned SPF_DIV8 [3][3] = '{
        '{48, 48, 48},
        '{144, 144, 144},
        '{144, 72, 72}
    };

    localparam int TOTAL_BYTES  = 850;
    localparam int STALL_LIMIT  = 2000;   // cycles with no transaction at all
    localparam int DRAIN_CYCLES = 40;
    localparam int DIR_ROWS     = 26;

    typedef struct packed {
        logic             found;
        logic [OFF_W-1:0] offset;
        logic [LEN_W-1:0] length;
    } t_sync_result;

    // one directed byte; the expected result is typed in only where marked
    typedef struct {
        logic [7:0]       data;
        logic             last;
        logic             typed;
        logic             found;
        logic [OFF_W-1:0] offset;
        logic [LEN_W-1:0] length;
    } t_stim_row;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_in_valid;
    logic             o_in_ready;
    logic [7:0]       i_data_byte;
    logic             i_last_byte;
    logic             o_out_valid;
    logic             i_out_ready;
    logic             o_found;
    logic [OFF_W-1:0] o_header_offset;
    logic [LEN_W-1:0] o_frame_length;

    mpeg_audio_frame_sync_finder_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_data_byte     (i_data_byte),
        .i_last_byte     (i_last_byte),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_found         (o_found),
        .o_header_offset (o_header_offset),
        .o_frame_length  (o_frame_length)
    );

    // hand-made buffers: a one-byte miss, the longest legal frame, a layer I
    // frame with padding, and one buffer holding every reserved field value
    t_stim_row dir_rows [DIR_ROWS] = '{
        '{8'h00, 1'b1, 1'b1, 1'b0, 17'd1,  12'd0},
        // mpeg2.5 layer II 160 kbps 8 khz padded, then a byte that is ignored
        '{8'hFF, 1'b0, 1'b0, 1'b0, 17'd0,  12'd0},
        '{8'hE5, 1'b0, 1'b0, 1'b0, 17'd0,  12'd0},
        '{8'hEA, 1'b0, 1'b0, 1'b0, 17'd0,  12'd0},
        '{8'h00, 1'b0, 1'b1, 1'b1, 17'd0,  12'd2881},
        '{8'h55, 1'b1, 1'b0, 1'b0, 17'd0,  12'd0},
        // mpeg1 layer I 32 kbps 48 khz padded, header ends on the last byte
        '{8'hFF, 1'b0, 1'b0, 1'b0, 17'd0,  12'd0},
        '{8'hFF, 1'b0, 1'b0, 1'b0, 17'd0,  12'd0},
        '{8'h16, 1'b0, 1'b0, 1'b0, 17'd0,  12'd0},
        '{8'h00, 1'b1, 1'b1, 1'b1, 17'd0,  12'd36},
        // reserved version, reserved layer, bitrate 0, bitrate 15, rate 3
        '{8'hFF, 1'b0, 1'b0, 1'b0, 17'd0,  12'd0},
        '{8'hEB, 1'b0, 1'b0, 1'b0, 17'd0,  12'd0},
        '{8'h90, 1'b0, 1'b0, 1'b0, 17'd0,  12'd0},
        '{8'hFF, 1'b0, 1'b0, 1'b0, 17'd0,  12'd0},
        '{8'hF9, 1'b0, 1'b0, 1'b0, 17'd0,  12'd0},
        '{8'h90, 1'b0, 1'b0, 1'b0, 17'd0,  12'd0},
        '{8'hFF, 1'b0, 1'b0, 1'b0, 17'd0,  12'd0},
        '{8'hFB, 1'b0, 1'b0, 1'b0, 17'd0,  12'd0},
        '{8'h00, 1'b0, 1'b0, 1'b0, 17'd0,  12'd0},
        '{8'hFF, 1'b0, 1'b0, 1'b0, 17'd0,  12'd0},
        '{8'hFB, 1'b0, 1'b0, 1'b0, 17'd0,  12'd0},
        '{8'hF0, 1'b0, 1'b0, 1'b0, 17'd0,  12'd0},
        '{8'hFF, 1'b0, 1'b0, 1'b0, 17'd0,  12'd0},
        '{8'hFB, 1'b0, 1'b0, 1'b0, 17'd0,  12'd0},
        '{8'h9C, 1'b0, 1'b0, 1'b0, 17'd0,  12'd0},
        '{8'h00, 1'b1, 1'b1, 1'b0, 17'd16, 12'd0}
    };

    // local copy of the scan state
    logic [31:0]      scan_window;
    logic [OFF_W-1:0] scan_count;
    logic             header_seen;

    t_sync_result pending_results [$];

    int  fail_count;
    int  sent_bytes;
    int  buffers_sent;
    int  results_checked;
    int  headers_found;
    int  rx_hold;
    int  quiet_cycles;
    bit  no_idle;

    // ------------------------------------------------------------------------
    // clock, and the watchdog on transactions
    // ------------------------------------------------------------------------
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // frame header decode: returns 1 on a legal header and its frame length
    // ------------------------------------------------------------------------
    function automatic logic decode_header(input logic [31:0] w,
                                           output logic [LEN_W-1:0] len);
        logic [1:0]  ver;
        logic [1:0]  lay;
        logic [1:0]  sri;
        logic [3:0]  bri;
        int unsigned li;
        int unsigned vi;
        int unsigned kbps;
        int unsigned nbytes;
        ver = w[20:19];
        lay = w[18:17];
        bri = w[15:12];
        sri = w[11:10];
        len = '0;
        if (w[31:21] != HDR_SYNC || ver == VER_RSVD || lay == LAYER_RSVD ||
            bri == BR_FREE || bri == BR_BAD || sri == SR_RSVD) begin
            return 1'b0;
        end
        li = 3 - int'(lay);    // 0 is layer I
        vi = (ver == VER_ONE) ? 0 : ((ver == VER_TWO) ? 1 : 2);
        kbps = (vi == 0) ? KBPS_V1[li][bri] : KBPS_LSF[li][bri];
        nbytes = (SPF_DIV8[li][vi] * kbps * 1000) / RATE_HZ[sri][vi];
        // padding slot is four bytes in layer I, one byte otherwise
        nbytes = nbytes + ((li == 0) ? 4 * int'(w[9]) : int'(w[9]));
        len = nbytes[LEN_W-1:0];
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // advance the local scan by one byte; returns 1 when a result is due
    // ------------------------------------------------------------------------
    function automatic logic scan_byte(input logic [7:0] b, input logic last,
                                       output t_sync_result res);
        logic             due;
        logic [LEN_W-1:0] len;
        due = 1'b0;
        res = '0;
        // past a match or past the byte limit nothing is scanned
        if (!header_seen && scan_count < OFF_W'(MAX_BUFFER_BYTES)) begin
            scan_window = {scan_window[23:0], b};
            scan_count = scan_count + 1'b1;
            if (decode_header(scan_window, len)) begin
                header_seen = 1'b1;
                res = '{found: 1'b1, offset: scan_count - OFF_W'(4), length: len};
                due = 1'b1;
            end
        end
        if (last) begin
            // buffer ended with no header: report its length
            if (!header_seen) begin
                res = '{found: 1'b0, offset: scan_count, length: '0};
                due = 1'b1;
            end
            scan_window = '0;
            scan_count = '0;
            header_seen = 1'b0;
        end
        return due;
    endfunction

    // gap length: mostly none, often short, now and then long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    // legal header with random fields, or one with a single field broken
    function automatic logic [31:0] make_header(input bit broken);
        logic [1:0]  ver;
        logic [31:0] w;
        case ($urandom_range(0, 2))
            0: ver = VER_ONE;
            1: ver = VER_TWO;
            default: ver = VER_TWO_5;
        endcase
        w = {HDR_SYNC, ver, 2'($urandom_range(1, 3)), 1'($urandom),
             4'($urandom_range(1, 14)), 2'($urandom_range(0, 2)), 1'($urandom),
             9'($urandom)};
        if (broken) begin
            case ($urandom_range(0, 5))
                0: w[21 + $urandom_range(0, 10)] = 1'b0;
                1: w[20:19] = VER_RSVD;
                2: w[18:17] = LAYER_RSVD;
                3: w[15:12] = BR_FREE;
                4: w[15:12] = BR_BAD;
                default: w[11:10] = SR_RSVD;
            endcase
        end
        return w;
    endfunction

    // ------------------------------------------------------------------------
    // byte channel: drive at the falling edge, hold until the transaction
    // ------------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic last,
                             input logic typed, input t_sync_result want);
        t_sync_result predicted;
        logic         due;
        int           gap;
        @(negedge i_clk);
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= last;
        do @(posedge i_clk); while (!o_in_ready);
        sent_bytes++;
        due = scan_byte(b, last, predicted);
        // typed rows carry their own expectation; the scan still advances
        if (typed) begin
            pending_results.push_back(want);
        end else if (due) begin
            pending_results.push_back(predicted);
        end
        if (last) buffers_sent++;
        gap = no_idle ? 0 : idle_len();
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // random buffer: mostly a legal header in noise, some with a broken
    // header, some pure noise, some noise rich in sync-like bytes
    task automatic send_random_buffer();
        int          kind;
        int          len;
        int          pos;
        int          pos2;
        logic [31:0] hdr;
        logic [31:0] hdr2;
        logic [7:0]  b;
        kind = $urandom_range(0, 9);
        len  = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                            : $urandom_range(1, 30);
        if (kind <= 7 && len < 4) len = $urandom_range(4, 30);
        pos  = (kind <= 7) ? $urandom_range(0, len - 4) : len;
        hdr  = make_header(kind >= 6);
        // a second legal header after the first, which must be ignored
        hdr2 = make_header(1'b0);
        pos2 = (kind <= 5 && len - pos >= 8 && $urandom_range(0, 2) == 0)
               ? pos + 4 : len;
        for (int i = 0; i < len; i++) begin
            if (i >= pos && i < pos + 4) begin
                b = hdr[31 - 8 * (i - pos) -: 8];
            end else if (i >= pos2 && i < pos2 + 4) begin
                b = hdr2[31 - 8 * (i - pos2) -: 8];
            end else if (kind == 9) begin
                case ($urandom_range(0, 2))
                    0: b = 8'hFF;
                    1: b = 8'($urandom_range(8'hE0, 8'hFF));
                    default: b = 8'($urandom);
                endcase
            end else begin
                b = 8'($urandom);
            end
            send_byte(b, i == len - 1, 1'b0, '0);
        end
    endtask

    // ------------------------------------------------------------------------
    // result channel: random back-pressure, checked against the oldest
    // predicted result
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (rx_hold > 0) begin
            i_out_ready <= 1'b0;
            rx_hold <= rx_hold - 1;
        end else begin
            i_out_ready <= 1'b1;
            if (!no_idle && $urandom_range(0, 2) == 0) rx_hold <= idle_len();
        end
    end

    always @(posedge i_clk) begin : result_check
        t_sync_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result found=%0d offset=%0d length=%0d",
                         $time, o_found, o_header_offset, o_frame_length);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                if (want.found) headers_found++;
                if (o_found !== want.found) begin
                    $display("%0t: found expected %0d actual %0d",
                             $time, want.found, o_found);
                    fail_count++;
                end
                if (o_header_offset !== want.offset) begin
                    $display("%0t: header_offset expected %0d actual %0d",
                             $time, want.offset, o_header_offset);
                    fail_count++;
                end
                if (o_frame_length !== want.length) begin
                    $display("%0t: frame_length expected %0d actual %0d",
                             $time, want.length, o_frame_length);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        t_sync_result want;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_data_byte  = '0;
        i_last_byte  = 1'b0;
        i_out_ready  = 1'b0;
        scan_window  = '0;
        scan_count   = '0;
        header_seen  = 1'b0;
        fail_count   = 0;
        sent_bytes   = 0;
        buffers_sent = 0;
        results_checked = 0;
        headers_found = 0;
        rx_hold      = 0;
        quiet_cycles = 0;
        no_idle      = 1'b0;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed buffers
        foreach (dir_rows[r]) begin
            want = '{found: dir_rows[r].found, offset: dir_rows[r].offset,
                     length: dir_rows[r].length};
            send_byte(dir_rows[r].data, dir_rows[r].last, dir_rows[r].typed, want);
        end

        // sender holds off until every result is back
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);

        // random buffers, some of them with no idling on either side
        while (sent_bytes < TOTAL_BYTES) begin
            no_idle = ($urandom_range(0, 5) == 0);
            send_random_buffer();
            if (buffers_sent == 30) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
                while (pending_results.size() != 0) @(posedge i_clk);
            end
        end
        no_idle = 1'b0;

        @(negedge i_clk);
        i_in_valid  <= 1'b0;
        i_last_byte <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d buffers, %0d results checked (%0d with a header)",
                 buffers_sent, results_checked, headers_found);
        $display("reserved fields, padding, length extremes and stalls included");
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

### filelist.f
design/mpa_sync_pkg.sv
design/mpa_sync_dp.sv
design/mpa_sync_ctrl.sv
design/mpeg_audio_frame_sync_finder_top.sv
tb/tb_top.sv
